/* design/sabs_pkg.sv */
// Shared types for the streaming box and bounding sphere block.
// No dependencies.
`timescale 1ns / 1ps

package sabs_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_SQ    = 11'b000_0000_0010,
        ST_SUM_A = 11'b000_0000_0100,
        ST_SUM_B = 11'b000_0000_1000,
        ST_CMP   = 11'b000_0001_0000,
        ST_SQRT  = 11'b000_0010_0000,
        ST_PREP  = 11'b000_0100_0000,
        ST_MUL   = 11'b000_1000_0000,
        ST_DIV   = 11'b001_0000_0000,
        ST_UPD   = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    localparam int unsigned NUM_AXES  = 3;
    localparam int unsigned NUM_LANES = 4;   // three axes plus the radius square

endpackage

/* design/streaming_aabb_and_bounding_sphere_top.sv */
// Streaming axis-aligned box and incremental bounding sphere, top level.
// Depends on sabs_pkg (state type, lane counts).
`timescale 1ns / 1ps

// Channel | Dir | Beat contents (lowest bits first)
// s_      | in  | tdata: pos_x, pos_y, pos_z; tuser: first_vertex
// m_      | out | tdata: min_x..z, max_x..z, center_x..z, radius
//
// Work per beat: a first vertex goes straight to the final state; a vertex
// inside the sphere runs the squares, the two sums and the compare; a vertex
// that grows the sphere also runs the square root, prep, multiply, divide and
// update steps. The work is done by the bit-serial shift-add multiplier lanes
// for squares and delta*(d-r), one-bit-a-cycle square root, restoring divider.
// Reset clears the sequencer, output valid and all bounds to zero.
// A new beat is taken whenever the sequencer is idle, even while the last
// result still waits in the output register; a stalled m_ side holds the
// sequencer in its final state until the register frees.
module streaming_aabb_and_bounding_sphere_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // pos_x, pos_y, pos_z, zero pad
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // first_vertex
    input  logic [0:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, center_x, center_y, center_z,
    // radius, zero pad
    output logic [((10*COORD_WIDTH-1+7)/8)*8-1:0] m_tdata
);

    localparam int W   = COORD_WIDTH;
    localparam int CW  = $clog2(W + 1);
    localparam int MDW = ((10*W-1+7)/8)*8;
    localparam int NA  = sabs_pkg::NUM_AXES;
    localparam int NL  = sabs_pkg::NUM_LANES;
    localparam logic [CW-1:0] LAST = CW'(W);
    localparam logic [W-2:0] RMAX = '1;

    sabs_pkg::state_t state_reg, state_next;

    // running bounds
    logic signed [W-1:0] min_reg [NA];
    logic signed [W-1:0] max_reg [NA];
    logic signed [W-1:0] ctr_reg [NA];
    logic [W-2:0]        rad_reg;

    // delta magnitude and sign per axis
    logic [W:0] mag_reg [NA];
    logic       neg_reg [NA];

    // serial lanes: multiplicand, high part (also divider remainder), low part
    logic [W:0]   a_reg  [NL];
    logic [W+1:0] hi_reg [NL];
    logic [W:0]   lo_reg [NL];

    logic [2*W+1:0] dist_reg;    // sum of squares, then square-root shifter
    logic [W:0]     root_reg;
    logic [W+2:0]   srem_reg;
    logic [W+1:0]   den_reg;
    logic [CW-1:0]  cnt_reg;

    logic           m_valid_reg;
    logic [MDW-1:0] m_data_reg;

    logic accept;
    logic out_free;
    logic cnt_done;

    // square-root step
    logic [W+4:0] sq_t;
    logic [W+4:0] sq_trial;
    logic         sq_ge;

    // growth prep
    logic [W:0] d_w;
    logic [W:0] r_ext;
    logic [W:0] dr_w;
    logic [W:0] nr_sum;
    logic [W:0] nr_w;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == sabs_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign cnt_done = (cnt_reg == LAST);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign sq_t     = {srem_reg, dist_reg[2*W+1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_t >= sq_trial);

    assign d_w    = root_reg;
    assign r_ext  = {2'b00, rad_reg};
    assign dr_w   = d_w - r_ext;
    assign nr_sum = (d_w >> 1) + (r_ext >> 1) + (W+1)'(d_w[0] & r_ext[0]);
    assign nr_w   = nr_sum;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sabs_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = s_tuser[0] ? sabs_pkg::ST_DONE : sabs_pkg::ST_SQ;
                end
            end
            sabs_pkg::ST_SQ:    if (cnt_done) state_next = sabs_pkg::ST_SUM_A;
            sabs_pkg::ST_SUM_A: state_next = sabs_pkg::ST_SUM_B;
            sabs_pkg::ST_SUM_B: state_next = sabs_pkg::ST_CMP;
            sabs_pkg::ST_CMP: begin
                if (dist_reg > {hi_reg[NL-1][W:0], lo_reg[NL-1]}) begin
                    state_next = sabs_pkg::ST_SQRT;
                end else begin
                    state_next = sabs_pkg::ST_DONE;
                end
            end
            sabs_pkg::ST_SQRT:  if (cnt_done) state_next = sabs_pkg::ST_PREP;
            sabs_pkg::ST_PREP:  state_next = sabs_pkg::ST_MUL;
            sabs_pkg::ST_MUL:   if (cnt_done) state_next = sabs_pkg::ST_DIV;
            sabs_pkg::ST_DIV:   if (cnt_done) state_next = sabs_pkg::ST_UPD;
            sabs_pkg::ST_UPD:   state_next = sabs_pkg::ST_DONE;
            sabs_pkg::ST_DONE:  if (out_free) state_next = sabs_pkg::ST_IDLE;
            default:            state_next = sabs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sabs_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            rad_reg     <= '0;
            for (int k = 0; k < NA; k++) begin
                min_reg[k] <= '0;
                max_reg[k] <= '0;
                ctr_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            // output register: load on the final state, clear once taken
            if (state_reg == sabs_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                sabs_pkg::ST_IDLE: begin
                    cnt_reg <= '0;
                    if (accept) begin
                        for (int k = 0; k < NA; k++) begin
                            logic signed [W-1:0] p;
                            logic signed [W:0]   dl;
                            p  = $signed(s_tdata[k*W +: W]);
                            dl = (W+1)'(p) - (W+1)'(ctr_reg[k]);
                            if (s_tuser[0]) begin
                                min_reg[k] <= p;
                                max_reg[k] <= p;
                                ctr_reg[k] <= p;
                            end else begin
                                if (p < min_reg[k]) min_reg[k] <= p;
                                if (p > max_reg[k]) max_reg[k] <= p;
                            end
                            neg_reg[k] <= dl[W];
                            mag_reg[k] <= dl[W] ? (W+1)'(-dl) : (W+1)'(dl);
                            a_reg[k]   <= dl[W] ? (W+1)'(-dl) : (W+1)'(dl);
                            lo_reg[k]  <= dl[W] ? (W+1)'(-dl) : (W+1)'(dl);
                            hi_reg[k]  <= '0;
                        end
                        a_reg[NL-1]  <= {2'b00, rad_reg};
                        lo_reg[NL-1] <= {2'b00, rad_reg};
                        hi_reg[NL-1] <= '0;
                        if (s_tuser[0]) rad_reg <= '0;
                    end
                end
                sabs_pkg::ST_SQ, sabs_pkg::ST_MUL: begin
                    // shift-add: one multiplier bit per cycle
                    for (int k = 0; k < NL; k++) begin
                        logic [W+2:0] sum;
                        sum = (W+3)'(hi_reg[k]) + (lo_reg[k][0] ? (W+3)'(a_reg[k]) : '0);
                        hi_reg[k] <= sum[W+2:1];
                        lo_reg[k] <= {sum[0], lo_reg[k][W:1]};
                    end
                    cnt_reg <= cnt_done ? '0 : cnt_reg + 1'b1;
                end
                sabs_pkg::ST_SUM_A: begin
                    dist_reg <= {hi_reg[0][W:0], lo_reg[0]} + {hi_reg[1][W:0], lo_reg[1]};
                end
                sabs_pkg::ST_SUM_B: begin
                    dist_reg <= dist_reg + {hi_reg[2][W:0], lo_reg[2]};
                end
                sabs_pkg::ST_CMP: begin
                    root_reg <= '0;
                    srem_reg <= '0;
                    cnt_reg  <= '0;
                end
                sabs_pkg::ST_SQRT: begin
                    // restoring square root, one root bit per cycle
                    root_reg <= {root_reg[W-1:0], sq_ge};
                    srem_reg <= sq_ge ? (W+3)'(sq_t - sq_trial) : sq_t[W+2:0];
                    dist_reg <= {dist_reg[2*W-1:0], 2'b00};
                    cnt_reg  <= cnt_done ? '0 : cnt_reg + 1'b1;
                end
                sabs_pkg::ST_PREP: begin
                    den_reg <= {d_w, 1'b0};
                    rad_reg <= (nr_w > (W+1)'(RMAX)) ? RMAX : nr_w[W-2:0];
                    for (int k = 0; k < NA; k++) begin
                        a_reg[k]  <= mag_reg[k];
                        hi_reg[k] <= '0;
                        lo_reg[k] <= dr_w;
                    end
                end
                sabs_pkg::ST_DIV: begin
                    // restoring division by 2d; quotient shifts into lo
                    for (int k = 0; k < NA; k++) begin
                        logic [W+2:0] t;
                        logic         ge;
                        t  = {hi_reg[k], lo_reg[k][W]};
                        ge = (t >= (W+3)'(den_reg));
                        hi_reg[k] <= ge ? (W+2)'(t - (W+3)'(den_reg)) : t[W+1:0];
                        lo_reg[k] <= {lo_reg[k][W-1:0], ge};
                    end
                    cnt_reg <= cnt_done ? '0 : cnt_reg + 1'b1;
                end
                sabs_pkg::ST_UPD: begin
                    for (int k = 0; k < NA; k++) begin
                        logic [W:0] nc;
                        nc = neg_reg[k] ? (W+1)'(ctr_reg[k]) - lo_reg[k]
                                        : (W+1)'(ctr_reg[k]) + lo_reg[k];
                        ctr_reg[k] <= $signed(nc[W-1:0]);
                    end
                end
                sabs_pkg::ST_DONE: begin
                    if (out_free) begin
                        m_data_reg  <= MDW'({rad_reg,
                                             ctr_reg[2], ctr_reg[1], ctr_reg[0],
                                             max_reg[2], max_reg[1], max_reg[0],
                                             min_reg[2], min_reg[1], min_reg[0]});
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
